// File: rtl/lcm_pkg.sv
// Shared types, codes and default sizes for the lag correlation matrix block.
package lcm_pkg;

    // Default sizes
    localparam int DEF_MAX_LEN   = 256;
    localparam int DEF_MAX_ORDER = 16;

    // Fixed field widths
    localparam int OP_W      = 3;
    localparam int SMP_W     = 16;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 40;
    localparam int ST_W      = 2;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int ORDCFG_W  = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VEC_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER   = 2'd1;

    // Item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_SIG = 3'd0,
        OP_LOAD_TGT = 3'd1,
        OP_COMPUTE  = 3'd2,
        OP_READ_MAT = 3'd3,
        OP_READ_VEC = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    // Controller to datapath command flags
    typedef struct packed {
        logic sig_we;
        logic tgt_we;
        logic mac_issue;
        logic mac_first;
        logic vec;
        logic wr_en;
        logic rd_mat;
        logic rd_vec;
    } t_dp_cmd;

endpackage

// File: rtl/lag_correlation_matrix_core.sv
// Top level of the lag correlation matrix block.
//
// Usage: one command channel. An item is taken when start is high and busy
// is low; op selects load signal sample, load target sample, compute, read
// matrix entry or read vector entry. Loads produce no result. A read returns
// its entry in the cycle after it is taken, on o_value and o_status marked
// by o_valid for a single cycle; the receiver must take it then. Loads and
// reads can follow one another every cycle.
// A compute item with enough signal samples loaded holds busy high while one
// multiply-accumulate unit walks the sample memories, one product per cycle;
// each entry is accumulated, drained and written. The item computes all
// order*(order+1)/2 matrix entries, and the order vector entries too when the
// target is loaded. Only the upper triangle of the matrix is stored.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
// the block is idle; any write to vec_len or order clears both ready flags.
// Reset restores vec_len 256 and order 16 and clears counters and ready
// flags; memory contents are left as they are.
module lag_correlation_matrix_core #(
    parameter int MAX_LEN   = lcm_pkg::DEF_MAX_LEN,
    parameter int MAX_ORDER = lcm_pkg::DEF_MAX_ORDER
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lcm_pkg::OP_W-1:0]          i_op,
    input  logic signed [lcm_pkg::SMP_W-1:0]  i_sample,
    input  logic [lcm_pkg::IDX_W-1:0]         i_row,
    input  logic [lcm_pkg::IDX_W-1:0]         i_col,
    output logic                              o_valid,
    output logic signed [lcm_pkg::VAL_W-1:0]  o_value,
    output logic [lcm_pkg::ST_W-1:0]          o_status,
    input  logic                              i_cfg_we,
    input  logic [lcm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lcm_pkg::CFG_W-1:0]         i_cfg_data
);
    import lcm_pkg::*;

    localparam int SIG_AW = $clog2(MAX_LEN + MAX_ORDER - 1);
    localparam int TGT_AW = $clog2(MAX_LEN);
    localparam int OW     = $clog2(MAX_ORDER);
    localparam int OCW    = $clog2(MAX_ORDER + 1);
    localparam int NW     = $clog2(MAX_LEN);

    t_dp_cmd                 cmd;
    logic [SIG_AW-1:0]       sig_addr;
    logic [TGT_AW-1:0]       tgt_addr;
    logic [OW-1:0]           idx_i, idx_j;
    logic [NW-1:0]           idx_n;
    logic [OCW-1:0]          ord;
    logic signed [VAL_W-1:0] rd_data;

    lcm_ctrl #(
        .MAX_LEN(MAX_LEN), .MAX_ORDER(MAX_ORDER), .SIG_AW(SIG_AW),
        .TGT_AW(TGT_AW), .OW(OW), .OCW(OCW), .NW(NW)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_row(i_row), .i_col(i_col),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_cmd(cmd), .o_sig_addr(sig_addr), .o_tgt_addr(tgt_addr),
        .o_idx_i(idx_i), .o_idx_j(idx_j), .o_idx_n(idx_n), .o_ord(ord),
        .o_valid(o_valid), .o_status(o_status)
    );

    lcm_dp #(
        .MAX_LEN(MAX_LEN), .MAX_ORDER(MAX_ORDER), .SIG_AW(SIG_AW),
        .TGT_AW(TGT_AW), .OW(OW), .OCW(OCW), .NW(NW)
    ) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_sample(i_sample),
        .i_row(i_row), .i_col(i_col), .i_sig_addr(sig_addr),
        .i_tgt_addr(tgt_addr), .i_idx_i(idx_i), .i_idx_j(idx_j),
        .i_idx_n(idx_n), .i_ord(ord), .o_rd_data(rd_data)
    );

    // Entries are only shown with an ok status
    assign o_value = (o_status == ST_OK) ? rd_data : '0;

    // A taken read gives a result in the next cycle
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_READ_MAT || i_op == OP_READ_VEC)) |=> o_valid)
        else $error("read item gave no result");

    // Every result stems from an item taken in the previous cycle
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy))
        else $error("result without a taken item");

    // No result appears while a compute is running
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> !o_valid)
        else $error("result during compute");

endmodule

// File: rtl/lcm_ctrl.sv
// Controller: configuration, load counters, ready flags and the compute sequencer.
module lcm_ctrl #(
    parameter int MAX_LEN   = lcm_pkg::DEF_MAX_LEN,
    parameter int MAX_ORDER = lcm_pkg::DEF_MAX_ORDER,
    parameter int SIG_AW    = 9,
    parameter int TGT_AW    = 8,
    parameter int OW        = 4,
    parameter int OCW       = 5,
    parameter int NW        = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lcm_pkg::OP_W-1:0]      i_op,
    input  logic [lcm_pkg::IDX_W-1:0]     i_row,
    input  logic [lcm_pkg::IDX_W-1:0]     i_col,
    input  logic                          i_cfg_we,
    input  logic [lcm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lcm_pkg::CFG_W-1:0]     i_cfg_data,
    output lcm_pkg::t_dp_cmd              o_cmd,
    output logic [SIG_AW-1:0]             o_sig_addr,
    output logic [TGT_AW-1:0]             o_tgt_addr,
    output logic [OW-1:0]                 o_idx_i,
    output logic [OW-1:0]                 o_idx_j,
    output logic [NW-1:0]                 o_idx_n,
    output logic [OCW-1:0]                o_ord,
    output logic                          o_valid,
    output logic [lcm_pkg::ST_W-1:0]      o_status
);
    import lcm_pkg::*;

    localparam int SIG_DEPTH = MAX_LEN + MAX_ORDER - 1;
    localparam int SCW       = $clog2(SIG_DEPTH + 1);
    localparam int TCW       = $clog2(MAX_LEN + 1);
    localparam int LW        = $clog2(MAX_LEN + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cfg_len, n_cfg_len;
    logic [ORDCFG_W-1:0] r_cfg_ord, n_cfg_ord;
    logic [SCW-1:0]     r_sig_cnt, n_sig_cnt;
    logic [TCW-1:0]     r_tgt_cnt, n_tgt_cnt;
    logic               r_mat_rdy, n_mat_rdy;
    logic               r_vec_rdy, n_vec_rdy;
    logic               r_tgt_ok, n_tgt_ok;
    logic               r_vec, n_vec;
    logic [OW-1:0]      r_i, n_i;
    logic [OW-1:0]      r_j, n_j;
    logic [NW-1:0]      r_n, n_n;
    logic               r_first, n_first;
    logic               r_dcnt, n_dcnt;
    logic               r_valid, n_valid;
    t_status            r_status, n_status;

    logic [LW-1:0]      len;
    logic [OCW-1:0]     ord;
    logic               accept;
    logic               last_n;
    logic               last_i;
    logic               last_j;

    // Effective register values after clamping
    always_comb begin
        if (r_cfg_len == '0) begin
            len = LW'(1);
        end else if (32'(r_cfg_len) > MAX_LEN) begin
            len = LW'(MAX_LEN);
        end else begin
            len = LW'(r_cfg_len);
        end
        if (r_cfg_ord == '0) begin
            ord = OCW'(1);
        end else if (32'(r_cfg_ord) > MAX_ORDER) begin
            ord = OCW'(MAX_ORDER);
        end else begin
            ord = OCW'(r_cfg_ord);
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign last_n = (32'(r_n) == 32'(len) - 1);
    assign last_i = (OCW'(r_i) == ord - OCW'(1));
    assign last_j = (OCW'(r_j) == ord - OCW'(1));

    // Next-state and command logic
    always_comb begin
        n_state   = r_state;
        n_cfg_len = r_cfg_len;
        n_cfg_ord = r_cfg_ord;
        n_sig_cnt = r_sig_cnt;
        n_tgt_cnt = r_tgt_cnt;
        n_mat_rdy = r_mat_rdy;
        n_vec_rdy = r_vec_rdy;
        n_tgt_ok  = r_tgt_ok;
        n_vec     = r_vec;
        n_i       = r_i;
        n_j       = r_j;
        n_n       = r_n;
        n_first   = r_first;
        n_dcnt    = r_dcnt;
        n_valid   = 1'b0;
        n_status  = r_status;
        o_cmd     = '0;
        o_cmd.vec = r_vec;

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_we && (i_cfg_idx == CFG_VEC_LEN || i_cfg_idx == CFG_ORDER)) begin
                    if (i_cfg_idx == CFG_VEC_LEN) begin
                        n_cfg_len = i_cfg_data;
                    end else begin
                        n_cfg_ord = i_cfg_data[ORDCFG_W-1:0];
                    end
                    n_mat_rdy = 1'b0;
                    n_vec_rdy = 1'b0;
                end
                if (accept) begin
                    unique case (i_op)
                        OP_LOAD_SIG: begin
                            if (32'(r_sig_cnt) < SIG_DEPTH) begin
                                o_cmd.sig_we = 1'b1;
                                n_sig_cnt    = r_sig_cnt + SCW'(1);
                            end
                        end
                        OP_LOAD_TGT: begin
                            if (32'(r_tgt_cnt) < MAX_LEN) begin
                                o_cmd.tgt_we = 1'b1;
                                n_tgt_cnt    = r_tgt_cnt + TCW'(1);
                            end
                        end
                        OP_COMPUTE: begin
                            n_mat_rdy = 1'b0;
                            n_vec_rdy = 1'b0;
                            n_sig_cnt = '0;
                            n_tgt_cnt = '0;
                            n_tgt_ok  = (32'(r_tgt_cnt) >= 32'(len));
                            if (32'(r_sig_cnt) >= 32'(len) + 32'(ord) - 1) begin
                                n_state = S_MAC;
                                n_vec   = 1'b0;
                                n_i     = '0;
                                n_j     = '0;
                                n_n     = '0;
                                n_first = 1'b1;
                            end
                        end
                        OP_READ_MAT: begin
                            o_cmd.rd_mat = 1'b1;
                            n_valid      = 1'b1;
                            if (!r_mat_rdy) begin
                                n_status = ST_NOT_READY;
                            end else if (32'(i_row) >= 32'(ord) || 32'(i_col) >= 32'(ord)) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_status = ST_OK;
                            end
                        end
                        OP_READ_VEC: begin
                            o_cmd.rd_vec = 1'b1;
                            n_valid      = 1'b1;
                            if (!r_vec_rdy) begin
                                n_status = ST_NOT_READY;
                            end else if (32'(i_row) >= 32'(ord)) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_status = ST_OK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MAC: begin
                // One product per cycle into the accumulator pipeline
                o_cmd.mac_issue = 1'b1;
                o_cmd.mac_first = r_first;
                n_first         = 1'b0;
                n_n             = r_n + NW'(1);
                if (last_n) begin
                    n_state = S_DRAIN;
                    n_dcnt  = 1'b0;
                end
            end
            S_DRAIN: begin
                n_dcnt = 1'b1;
                if (r_dcnt) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                // Store the finished sum and step to the next entry
                o_cmd.wr_en = 1'b1;
                n_n         = '0;
                n_first     = 1'b1;
                n_state     = S_MAC;
                if (!r_vec) begin
                    if (last_j) begin
                        if (last_i) begin
                            n_mat_rdy = 1'b1;
                            if (r_tgt_ok) begin
                                n_vec = 1'b1;
                                n_i   = '0;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_i = r_i + OW'(1);
                            n_j = r_i + OW'(1);
                        end
                    end else begin
                        n_j = r_j + OW'(1);
                    end
                end else begin
                    if (last_i) begin
                        n_vec_rdy = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_i = r_i + OW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg_len <= CFG_W'(256);
            r_cfg_ord <= ORDCFG_W'(16);
            r_sig_cnt <= '0;
            r_tgt_cnt <= '0;
            r_mat_rdy <= 1'b0;
            r_vec_rdy <= 1'b0;
            r_tgt_ok  <= 1'b0;
            r_vec     <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_n       <= '0;
            r_first   <= 1'b0;
            r_dcnt    <= 1'b0;
            r_valid   <= 1'b0;
            r_status  <= ST_OK;
        end else begin
            r_state   <= n_state;
            r_cfg_len <= n_cfg_len;
            r_cfg_ord <= n_cfg_ord;
            r_sig_cnt <= n_sig_cnt;
            r_tgt_cnt <= n_tgt_cnt;
            r_mat_rdy <= n_mat_rdy;
            r_vec_rdy <= n_vec_rdy;
            r_tgt_ok  <= n_tgt_ok;
            r_vec     <= n_vec;
            r_i       <= n_i;
            r_j       <= n_j;
            r_n       <= n_n;
            r_first   <= n_first;
            r_dcnt    <= n_dcnt;
            r_valid   <= n_valid;
            r_status  <= n_status;
        end
    end

    assign o_sig_addr = SIG_AW'(r_sig_cnt);
    assign o_tgt_addr = TGT_AW'(r_tgt_cnt);
    assign o_idx_i    = r_i;
    assign o_idx_j    = r_j;
    assign o_idx_n    = r_n;
    assign o_ord      = ord;
    assign o_valid    = r_valid;
    assign o_status   = r_status;

endmodule

// File: rtl/lcm_dp.sv
// Datapath: sample, target, matrix and vector memories with the multiply-accumulate pipeline.
module lcm_dp #(
    parameter int MAX_LEN   = lcm_pkg::DEF_MAX_LEN,
    parameter int MAX_ORDER = lcm_pkg::DEF_MAX_ORDER,
    parameter int SIG_AW    = 9,
    parameter int TGT_AW    = 8,
    parameter int OW        = 4,
    parameter int OCW       = 5,
    parameter int NW        = 8
) (
    input  logic                              i_clk,
    input  lcm_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [lcm_pkg::SMP_W-1:0]  i_sample,
    input  logic [lcm_pkg::IDX_W-1:0]         i_row,
    input  logic [lcm_pkg::IDX_W-1:0]         i_col,
    input  logic [SIG_AW-1:0]                 i_sig_addr,
    input  logic [TGT_AW-1:0]                 i_tgt_addr,
    input  logic [OW-1:0]                     i_idx_i,
    input  logic [OW-1:0]                     i_idx_j,
    input  logic [NW-1:0]                     i_idx_n,
    input  logic [OCW-1:0]                    i_ord,
    output logic signed [lcm_pkg::VAL_W-1:0]  o_rd_data
);
    import lcm_pkg::*;

    localparam int SIG_DEPTH = MAX_LEN + MAX_ORDER - 1;
    localparam int MAT_DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int MAW       = $clog2(MAT_DEPTH);
    localparam int PW        = 2 * SMP_W;
    localparam int ACC_RAW   = PW + 1 + $clog2(MAX_LEN);
    localparam int ACCW      = (ACC_RAW > VAL_W + 1) ? ACC_RAW : VAL_W + 1;
    localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(64'sd549755813887);
    localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);

    logic signed [SMP_W-1:0] sig_mem [SIG_DEPTH];
    logic signed [SMP_W-1:0] tgt_mem [MAX_LEN];
    logic signed [VAL_W-1:0] mat_mem [MAT_DEPTH];
    logic signed [VAL_W-1:0] vec_mem [MAX_ORDER];

    logic [SIG_AW-1:0]       addr_a, addr_b;
    logic [TGT_AW-1:0]       addr_t;
    logic [MAW-1:0]          wr_maddr, rd_maddr;
    logic [OW-1:0]           rd_r, rd_c, row_t, col_t;
    logic signed [SMP_W-1:0] r_xa, r_xb, r_xt;
    logic                    r_v1, r_f1, r_v2, r_f2;
    logic signed [PW-1:0]    r_prod;
    logic signed [ACCW-1:0]  r_acc;
    logic signed [VAL_W-1:0] sat_val;
    logic signed [VAL_W-1:0] r_rd_q;

    // Operand addresses for the current product
    assign addr_a = SIG_AW'(32'(i_ord) - 1 - 32'(i_idx_i) + 32'(i_idx_n));
    assign addr_b = SIG_AW'(32'(i_ord) - 1 - 32'(i_idx_j) + 32'(i_idx_n));
    assign addr_t = TGT_AW'(i_idx_n);

    // Only the upper triangle is stored; reads fold onto it
    assign wr_maddr = MAW'(32'(i_idx_i) * MAX_ORDER + 32'(i_idx_j));
    assign row_t    = OW'(i_row);
    assign col_t    = OW'(i_col);
    assign rd_r     = (row_t <= col_t) ? row_t : col_t;
    assign rd_c     = (row_t <= col_t) ? col_t : row_t;
    assign rd_maddr = MAW'(32'(rd_r) * MAX_ORDER + 32'(rd_c));

    // Sample and target memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.sig_we) begin
            sig_mem[i_sig_addr] <= i_sample;
        end
        r_xa <= sig_mem[addr_a];
        r_xb <= sig_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt_we) begin
            tgt_mem[i_tgt_addr] <= i_sample;
        end
        r_xt <= tgt_mem[addr_t];
    end

    // Multiply then accumulate, one register per step
    always_ff @(posedge i_clk) begin
        r_v1   <= i_cmd.mac_issue;
        r_f1   <= i_cmd.mac_first;
        r_v2   <= r_v1;
        r_f2   <= r_f1;
        r_prod <= r_xa * (i_cmd.vec ? r_xt : r_xb);
        if (r_v2) begin
            r_acc <= r_f2 ? ACCW'(r_prod) : r_acc + ACCW'(r_prod);
        end
    end

    // Saturate the finished sum to the result width
    always_comb begin
        if (r_acc > SAT_HI) begin
            sat_val = VAL_W'(SAT_HI);
        end else if (r_acc < SAT_LO) begin
            sat_val = VAL_W'(SAT_LO);
        end else begin
            sat_val = VAL_W'(r_acc);
        end
    end

    // Result memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && !i_cmd.vec) begin
            mat_mem[wr_maddr] <= sat_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && i_cmd.vec) begin
            vec_mem[i_idx_i] <= sat_val;
        end
    end

    // Registered read of the requested entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_mat) begin
            r_rd_q <= mat_mem[rd_maddr];
        end else if (i_cmd.rd_vec) begin
            r_rd_q <= vec_mem[row_t];
        end
    end

    assign o_rd_data = r_rd_q;

endmodule
